>>> hw/rtl/assert_macros.svh
// assertion helpers, clocked on clk with rst_n as disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LJ_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lj pair force check failed");

`define LJ_ASSERT_IMPLY(lbl, ante, cons) \
    `LJ_ASSERT(lbl, (ante) |-> (cons))

`endif

>>> hw/rtl/lj_pkg.sv
package lj_pkg;

    localparam int REG_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int RSQ_W       = 40;
    localparam int NUM_W       = 64;
    localparam int FORCE_W     = 32;
    localparam int MIN_RSQ     = 43;
    localparam int LJ_SCALE    = 24;
    localparam int CUT_SHIFT   = 16;
    localparam int S2_SHIFT    = 40;
    localparam int IR_SHIFT    = 56;
    localparam int DIV_LAT     = NUM_W;
    localparam int MUL_LAT     = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [NUM_W-1:0]   POS_LIM   = NUM_W'(64'h7FFF_FFFF);
    localparam logic [NUM_W-1:0]   NEG_LIM   = NUM_W'(64'h8000_0000);
    localparam logic [FORCE_W-1:0] POS_CLIP  = 32'h7FFF_FFFF;
    localparam logic [FORCE_W-1:0] NEG_CLIP  = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_X    = 3'd0,
        REG_BOX_Y    = 3'd1,
        REG_BOX_Z    = 3'd2,
        REG_CUTOFF   = 3'd3,
        REG_EPS      = 3'd4,
        REG_SIGMA_SQ = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [RSQ_W-1:0] rsq;
        logic             in_range;
        logic [2:0]       dneg;
    } pair_ctl_t;

endpackage

>>> hw/rtl/lennard_jones_pair_force_unit.sv
// Lennard-Jones 12-6 pair force with periodic minimum image. Takes one neighbor pair per
// cycle while in_ready is high and returns one force item per pair, in order. A pair passes
// the front (fold, squares and range test), a four-entry queue and then the back, whose
// length is set by the 64-stage one-bit-per-stage dividers for sigma^2/rsq and 1/rsq and
// the chain of six two-stage multipliers behind them. Registers are written through
// cfg_wr_en, cfg_index, cfg_data while no pair is in flight: the user must keep to this,
// the block itself does not enforce it. The block is ready straight after reset.
module lennard_jones_pair_force_unit
    import lj_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [REG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COORD_WIDTH-1:0]      i_x,
    input  logic [COORD_WIDTH-1:0]      i_y,
    input  logic [COORD_WIDTH-1:0]      i_z,
    input  logic [COORD_WIDTH-1:0]      j_x,
    input  logic [COORD_WIDTH-1:0]      j_y,
    input  logic [COORD_WIDTH-1:0]      j_z,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [FORCE_W-1:0]   force_x,
    output logic signed [FORCE_W-1:0]   force_y,
    output logic signed [FORCE_W-1:0]   force_z,
    output logic                        in_range,
    output logic                        saturated
);

    `include "assert_macros.svh"

    localparam int W      = COORD_WIDTH;
    localparam int DATA_W = $bits(pair_ctl_t) + 3 * W;

    logic [REG_W-1:0] box_x_reg, box_y_reg, box_z_reg;
    logic [REG_W-1:0] cutoff_reg, eps_reg, sigma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg  <= 24'd327680;
            box_y_reg  <= 24'd327680;
            box_z_reg  <= 24'd327680;
            cutoff_reg <= 24'd65536;
            eps_reg    <= 24'd32768;
            sigma_reg  <= 24'd5898;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BOX_X:    box_x_reg  <= cfg_data;
                REG_BOX_Y:    box_y_reg  <= cfg_data;
                REG_BOX_Z:    box_z_reg  <= cfg_data;
                REG_CUTOFF:   cutoff_reg <= cfg_data;
                REG_EPS:      eps_reg    <= cfg_data;
                REG_SIGMA_SQ: sigma_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    logic              q_push, q_full, q_pop, q_valid;
    pair_ctl_t         f_ctl, b_ctl;
    logic [2:0][W-1:0] f_mag, b_mag;
    logic [DATA_W-1:0] q_rd;
    logic [2:0][FORCE_W-1:0] force_vec;

    lj_front #(.W(W)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ci        ({i_z, i_y, i_x}),
        .cj        ({j_z, j_y, j_x}),
        .box       ({W'(box_z_reg), W'(box_y_reg), W'(box_x_reg)}),
        .cutoff_sq (cutoff_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_ctl     (f_ctl),
        .q_mag     (f_mag)
    );

    lj_fifo #(.DATA_W(DATA_W)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data ({f_ctl, f_mag}),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_data (q_rd)
    );

    assign {b_ctl, b_mag} = q_rd;

    lj_back #(.W(W)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_ctl      (b_ctl),
        .q_mag      (b_mag),
        .well_depth (eps_reg),
        .sigma_sq   (sigma_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .force_out  (force_vec),
        .in_range   (in_range),
        .saturated  (saturated)
    );

    assign force_x = force_vec[0];
    assign force_y = force_vec[1];
    assign force_z = force_vec[2];

    `LJ_ASSERT(a_no_push_when_full, !(q_push && q_full))
    `LJ_ASSERT(a_no_pop_when_empty, !(q_pop && !q_valid))
    `LJ_ASSERT_IMPLY(a_out_of_range_zero, out_valid && !in_range,
        force_x == 0 && force_y == 0 && force_z == 0 && !saturated)
    `LJ_ASSERT_IMPLY(a_sat_at_limit, out_valid && saturated,
        force_x == 32'sh7FFF_FFFF || force_x == 32'sh8000_0000
        || force_y == 32'sh7FFF_FFFF || force_y == 32'sh8000_0000
        || force_z == 32'sh7FFF_FFFF || force_z == 32'sh8000_0000)

endmodule

>>> hw/rtl/lj_front.sv
module lj_front
    import lj_pkg::*;
#(
    parameter int W = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0][W-1:0]     ci,
    input  logic [2:0][W-1:0]     cj,
    input  logic [2:0][W-1:0]     box,
    input  logic [REG_W-1:0]      cutoff_sq,
    input  logic                  q_full,
    output logic                  q_push,
    output pair_ctl_t             q_ctl,
    output logic [2:0][W-1:0]     q_mag
);

    localparam int SQ_W  = 2 * W;
    localparam int SUM_W = (SQ_W + 2 > RSQ_W + 1) ? SQ_W + 2 : RSQ_W + 1;

    logic en;
    logic v1_reg, v2_reg;
    logic [2:0][W-1:0]    mag1_reg, mag2_reg, mag1_next;
    logic [2:0]           dneg1_reg, dneg2_reg, dneg1_next;
    logic [2:0][SQ_W-1:0] sq2_reg;
    logic signed [W+1:0]  d [3];
    logic signed [W+1:0]  f [3];
    logic signed [W+1:0]  bs [3];
    logic signed [W+1:0]  fa [3];
    logic signed [W+2:0]  dd [3];
    logic signed [W+2:0]  bb [3];
    logic [SUM_W-1:0]     rsq_sum;
    logic [SUM_W-1:0]     cut_lim;

    assign en       = !(v2_reg && q_full);
    assign in_ready = en;
    assign q_push   = v2_reg && en;

    // minimum image fold per axis
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d[k]  = $signed({2'b00, ci[k]}) - $signed({2'b00, cj[k]});
            bs[k] = $signed({2'b00, box[k]});
            dd[k] = $signed({d[k], 1'b0});
            bb[k] = $signed({3'b000, box[k]});
            if (dd[k] >= bb[k])
            begin
                f[k] = d[k] - bs[k];
            end
            else if (dd[k] <= -bb[k])
            begin
                f[k] = d[k] + bs[k];
            end
            else
            begin
                f[k] = d[k];
            end
            dneg1_next[k] = f[k][W+1];
            fa[k]         = f[k][W+1] ? -f[k] : f[k];
            mag1_next[k]  = fa[k][W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= mag1_next;
            dneg1_reg <= dneg1_next;
            mag2_reg  <= mag1_reg;
            dneg2_reg <= dneg1_reg;
            for (int k = 0; k < 3; k++)
            begin
                sq2_reg[k] <= SQ_W'(mag1_reg[k]) * SQ_W'(mag1_reg[k]);
            end
        end
    end

    assign rsq_sum = SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1]) + SUM_W'(sq2_reg[2]);
    assign cut_lim = SUM_W'({cutoff_sq, {CUT_SHIFT{1'b0}}});

    assign q_ctl.rsq      = rsq_sum[RSQ_W-1:0];
    assign q_ctl.in_range = (rsq_sum < cut_lim) && (rsq_sum >= SUM_W'(MIN_RSQ));
    assign q_ctl.dneg     = dneg2_reg;
    assign q_mag          = mag2_reg;

endmodule

>>> hw/rtl/lj_fifo.sv
module lj_fifo
    import lj_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output logic [DATA_W-1:0] rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    cnt_reg;

    assign full    = (cnt_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hw/rtl/lj_div.sv
module lj_div
    import lj_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [RSQ_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [RSQ_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [RSQ_W-1:0] den_reg [NUM_W];

    // one quotient bit per stage, restoring
    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic [RSQ_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [NUM_W-1:0] quo_in;
        logic [RSQ_W-1:0] den_in;
        logic [RSQ_W:0]   trial;
        logic             ge;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = num;
            assign quo_in = '0;
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign num_in = num_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        assign trial = {rem_in, num_in[NUM_W-1]};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? RSQ_W'(trial - {1'b0, den_in}) : trial[RSQ_W-1:0];
                num_reg[s] <= {num_in[NUM_W-2:0], 1'b0};
                quo_reg[s] <= {quo_in[NUM_W-2:0], ge};
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = quo_reg[NUM_W-1];

endmodule

>>> hw/rtl/lj_mul.sv
module lj_mul
    import lj_pkg::*;
#(
    parameter int SH = 24
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] a,
    input  logic [NUM_W-1:0] b,
    output logic [NUM_W-1:0] y
);

    localparam int HW = NUM_W / 2;
    localparam int PW = 2 * NUM_W;

    logic [NUM_W-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [NUM_W-1:0] y_reg, y_next;
    logic [PW-1:0]    full;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= NUM_W'(a[HW-1:0]) * NUM_W'(b[HW-1:0]);
            lh_reg <= NUM_W'(a[HW-1:0]) * NUM_W'(b[NUM_W-1:HW]);
            hl_reg <= NUM_W'(a[NUM_W-1:HW]) * NUM_W'(b[HW-1:0]);
            hh_reg <= NUM_W'(a[NUM_W-1:HW]) * NUM_W'(b[NUM_W-1:HW]);
            y_reg  <= y_next;
        end
    end

    // shift down and saturate at all ones
    always_comb
    begin
        full = (PW'(hh_reg) << NUM_W) + (PW'(lh_reg) << HW) + (PW'(hl_reg) << HW)
             + PW'(ll_reg);
        y_next = (|full[PW-1:NUM_W+SH]) ? '1 : full[NUM_W+SH-1:SH];
    end

    assign y = y_reg;

endmodule

>>> hw/rtl/lj_back.sv
module lj_back
    import lj_pkg::*;
#(
    parameter int W = 24
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    output logic                      q_pop,
    input  pair_ctl_t                 q_ctl,
    input  logic [2:0][W-1:0]         q_mag,
    input  logic [REG_W-1:0]          well_depth,
    input  logic [REG_W-1:0]          sigma_sq,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2:0][FORCE_W-1:0]   force_out,
    output logic                      in_range,
    output logic                      saturated
);

    localparam int S_G    = DIV_LAT + 3 * MUL_LAT + 1;
    localparam int LAST   = S_G + 3 * MUL_LAT;
    localparam int IR_DLY = 4 * MUL_LAT + 1;
    localparam int GN_DLY = 3 * MUL_LAT;

    logic en;
    logic [LAST:1]     vld_reg;
    pair_ctl_t         ctl_reg [1:LAST];
    logic [2:0][W-1:0] mag_reg [1:LAST];

    logic [NUM_W-1:0] s2, ir, s4, s6, s12, t, fr;
    logic [NUM_W-1:0] s2_d_reg [MUL_LAT];
    logic [NUM_W-1:0] s6_d_reg [MUL_LAT];
    logic [NUM_W-1:0] ir_d_reg [IR_DLY];
    logic             gn_d_reg [GN_DLY];
    logic [NUM_W-1:0] g_reg, g_next, p;
    logic             gneg_reg, gneg_next;
    logic [2:0][NUM_W-1:0] magf;

    logic                      out_valid_reg, in_range_reg, sat_reg, sat_next;
    logic [2:0][FORCE_W-1:0]   force_reg, force_next;
    logic                      neg [3];

    assign en    = !out_valid_reg || out_ready;
    assign q_pop = q_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[LAST-1:1], q_valid};
            out_valid_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[1] <= q_ctl;
            mag_reg[1] <= q_mag;
            for (int k = 2; k <= LAST; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
                mag_reg[k] <= mag_reg[k-1];
            end
        end
    end

    lj_div u_div_s2
    (
        .clk (clk),
        .en  (en),
        .num ({sigma_sq, {S2_SHIFT{1'b0}}}),
        .den (q_ctl.rsq),
        .quo (s2)
    );

    lj_div u_div_ir
    (
        .clk (clk),
        .en  (en),
        .num (NUM_W'(1) << IR_SHIFT),
        .den (q_ctl.rsq),
        .quo (ir)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_d_reg[0] <= s2;
            s6_d_reg[0] <= s6;
            for (int k = 1; k < MUL_LAT; k++)
            begin
                s2_d_reg[k] <= s2_d_reg[k-1];
                s6_d_reg[k] <= s6_d_reg[k-1];
            end
            ir_d_reg[0] <= ir;
            for (int k = 1; k < IR_DLY; k++)
            begin
                ir_d_reg[k] <= ir_d_reg[k-1];
            end
            gn_d_reg[0] <= gneg_reg;
            for (int k = 1; k < GN_DLY; k++)
            begin
                gn_d_reg[k] <= gn_d_reg[k-1];
            end
            g_reg    <= g_next;
            gneg_reg <= gneg_next;
        end
    end

    lj_mul #(.SH(24)) u_mul_s4 (.clk(clk), .en(en), .a(s2), .b(s2), .y(s4));
    lj_mul #(.SH(24)) u_mul_s6
    (
        .clk (clk), .en (en), .a (s4), .b (s2_d_reg[MUL_LAT-1]), .y (s6)
    );
    lj_mul #(.SH(24)) u_mul_s12 (.clk(clk), .en(en), .a(s6), .b(s6), .y(s12));

    // 2*s12 - s6 as sign and magnitude
    always_comb
    begin
        p         = s12[NUM_W-1] ? '1 : {s12[NUM_W-2:0], 1'b0};
        gneg_next = (p < s6_d_reg[MUL_LAT-1]);
        g_next    = gneg_next ? s6_d_reg[MUL_LAT-1] - p : p - s6_d_reg[MUL_LAT-1];
    end

    lj_mul #(.SH(16)) u_mul_t
    (
        .clk (clk), .en (en),
        .a   (NUM_W'(LJ_SCALE) * NUM_W'(well_depth)),
        .b   (g_reg), .y (t)
    );
    lj_mul #(.SH(24)) u_mul_fr
    (
        .clk (clk), .en (en), .a (t), .b (ir_d_reg[IR_DLY-1]), .y (fr)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        lj_mul #(.SH(24)) u_mul_mag
        (
            .clk (clk), .en (en), .a (fr),
            .b   (NUM_W'(mag_reg[LAST-MUL_LAT][k])),
            .y   (magf[k])
        );
    end

    // sign, clip and out of range zeroing
    always_comb
    begin
        sat_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            neg[k] = gn_d_reg[GN_DLY-1] ^ ctl_reg[LAST].dneg[k];
            if (!neg[k])
            begin
                if (magf[k] > POS_LIM)
                begin
                    force_next[k] = POS_CLIP;
                    sat_next      = 1'b1;
                end
                else
                begin
                    force_next[k] = magf[k][FORCE_W-1:0];
                end
            end
            else
            begin
                if (magf[k] > NEG_LIM)
                begin
                    force_next[k] = NEG_CLIP;
                    sat_next      = 1'b1;
                end
                else
                begin
                    force_next[k] = -magf[k][FORCE_W-1:0];
                end
            end
        end
        if (!ctl_reg[LAST].in_range)
        begin
            force_next = '0;
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            force_reg    <= force_next;
            sat_reg      <= sat_next;
            in_range_reg <= ctl_reg[LAST].in_range;
        end
    end

    assign out_valid = out_valid_reg;
    assign force_out = force_reg;
    assign in_range  = in_range_reg;
    assign saturated = sat_reg;

endmodule

>>> tb/tb_lennard_jones_pair_force_unit.sv
module tb_lennard_jones_pair_force_unit
    import lj_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 24;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [CW-1:0] ix, iy, iz, jx, jy, jz;
    } pair_t;

    typedef struct packed {
        logic [31:0] fx, fy, fz;
        logic        rng;
        logic        sat;
    } force_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CW-1:0] i_x = '0, i_y = '0, i_z = '0, j_x = '0, j_y = '0, j_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] force_x, force_y, force_z;
    logic in_range, saturated;

    logic [23:0] box_x, box_y, box_z, cut_sq, eps, sig_sq;
    force_t expected_forces[$];
    int errors = 0;
    int pairs_sent = 0;
    int forces_seen = 0;
    int in_range_seen = 0;
    int sat_seen = 0;
    bit sink_steady = 1'b0;

    lennard_jones_pair_force_unit #(.COORD_WIDTH(CW)) u_top (.*);

    always #10 clk = ~clk;

    initial
    begin
        #100_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = a * b;
        p = p >> sh;
        return (p[127:64] != 0) ? ALL_ONES : p[63:0];
    endfunction

    function automatic logic signed [63:0] fold_axis(logic [CW-1:0] ci, logic [CW-1:0] cj,
                                                   logic [23:0] box);
        logic signed [63:0] d, b;
        d = $signed({40'b0, ci}) - $signed({40'b0, cj});
        b = $signed({40'b0, box});
        if (2 * d >= b)
            d = d - b;
        else if (2 * d <= -b)
            d = d + b;
        return d;
    endfunction

    function automatic force_t pair_force(pair_t p);
        force_t r;
        logic signed [63:0] d[3];
        logic [63:0] m[3];
        logic [64:0] acc;
        logic [63:0] rsq, s2, s4, s6, s12, dbl, g, ir, t, fr, mag;
        logic gneg, neg;
        r = '0;
        d[0] = fold_axis(p.ix, p.jx, box_x);
        d[1] = fold_axis(p.iy, p.jy, box_y);
        d[2] = fold_axis(p.iz, p.jz, box_z);
        acc = 0;
        for (int k = 0; k < 3; k++)
        begin
            m[k] = d[k] < 0 ? -d[k] : d[k];
            acc = acc + (m[k] * m[k]);
            if (acc[64])
                acc = {1'b0, ALL_ONES};
        end
        rsq = acc[63:0];
        if (!(rsq < ({40'b0, cut_sq} << 16) && rsq >= MIN_RSQ))
            return r;
        s2 = ({40'b0, sig_sq} << 40) / rsq;
        s4 = mul_shift(s2, s2, 24);
        s6 = mul_shift(s4, s2, 24);
        s12 = mul_shift(s6, s6, 24);
        dbl = s12[63] ? ALL_ONES : {s12[62:0], 1'b0};
        gneg = dbl < s6;
        g = gneg ? s6 - dbl : dbl - s6;
        ir = (64'd1 << 56) / rsq;
        t = mul_shift(64'(LJ_SCALE) * {40'b0, eps}, g, 16);
        fr = mul_shift(t, ir, 24);
        for (int k = 0; k < 3; k++)
        begin
            mag = mul_shift(fr, m[k], 24);
            neg = gneg ^ (d[k] < 0);
            if (!neg && mag > 64'h7FFF_FFFF)
            begin
                mag = 64'h7FFF_FFFF;
                r.sat = 1'b1;
            end
            else if (neg && mag > 64'h8000_0000)
            begin
                mag = 64'h8000_0000;
                r.sat = 1'b1;
            end
            if (neg)
                mag = -mag;
            case (k)
                0: r.fx = mag[31:0];
                1: r.fy = mag[31:0];
                default: r.fz = mag[31:0];
            endcase
        end
        r.rng = 1'b1;
        return r;
    endfunction

    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return 0;
        if (sel < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result sink with random stalls
    always @(posedge clk)
    begin
        if (!rst_n || sink_steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 9) < 7) ? 1'b1
                         : ($urandom_range(0, 19) == 0 ? 1'b0 : out_ready ^ 1'b1);
    end

    always @(posedge clk)
    begin
        force_t want;
        if (rst_n && out_valid && out_ready)
        begin
            forces_seen++;
            if (in_range)
                in_range_seen++;
            if (saturated)
                sat_seen++;
            if (expected_forces.size() == 0)
            begin
                $error("force item with nothing expected");
                errors++;
            end
            else
            begin
                want = expected_forces.pop_front();
                if (force_x !== want.fx)
                begin
                    $error("force_x expected %h actual %h", want.fx, force_x);
                    errors++;
                end
                if (force_y !== want.fy)
                begin
                    $error("force_y expected %h actual %h", want.fy, force_y);
                    errors++;
                end
                if (force_z !== want.fz)
                begin
                    $error("force_z expected %h actual %h", want.fz, force_z);
                    errors++;
                end
                if (in_range !== want.rng)
                begin
                    $error("in_range expected %b actual %b", want.rng, in_range);
                    errors++;
                end
                if (saturated !== want.sat)
                begin
                    $error("saturated expected %b actual %b", want.sat, saturated);
                    errors++;
                end
            end
        end
    end

    task automatic send_pair(pair_t p, bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {i_x, i_y, i_z, j_x, j_y, j_z} <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_forces.push_back(pair_force(p));
        pairs_sent++;
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (expected_forces.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_BOX_X:  box_x = val;
            REG_BOX_Y:  box_y = val;
            REG_BOX_Z:  box_z = val;
            REG_CUTOFF: cut_sq = val;
            REG_EPS:    eps = val;
            default:    sig_sq = val;
        endcase
    endtask

    task automatic set_all(logic [23:0] bx, logic [23:0] by, logic [23:0] bz,
                           logic [23:0] c, logic [23:0] e, logic [23:0] s);
        write_reg(REG_BOX_X, bx);
        write_reg(REG_BOX_Y, by);
        write_reg(REG_BOX_Z, bz);
        write_reg(REG_CUTOFF, c);
        write_reg(REG_EPS, e);
        write_reg(REG_SIGMA_SQ, s);
    endtask

    function automatic pair_t near_pair(logic [23:0] lim, int spread);
        pair_t p;
        logic [23:0] hi;
        hi = (lim > 1) ? lim - 1 : 0;
        p.ix = CW'($urandom_range(0, hi));
        p.iy = CW'($urandom_range(0, hi));
        p.iz = CW'($urandom_range(0, hi));
        p.jx = CW'((p.ix + $urandom_range(0, 2 * spread) - spread) % (hi + 1));
        p.jy = CW'((p.iy + $urandom_range(0, 2 * spread) - spread) % (hi + 1));
        p.jz = CW'((p.iz + $urandom_range(0, 2 * spread) - spread) % (hi + 1));
        return p;
    endfunction

    task automatic test_directed();
        // coincident atoms, too close
        send_pair('{24'd100, 24'd100, 24'd100, 24'd100, 24'd100, 24'd100});
        // just above and just below the minimum distance
        send_pair('{24'd7, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
        send_pair('{24'd6, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
        // typical separations, both signs
        send_pair('{24'd30000, 24'd20000, 24'd10000, 24'd0, 24'd0, 24'd0});
        send_pair('{24'd0, 24'd0, 24'd0, 24'd30000, 24'd20000, 24'd10000});
        send_pair('{24'd200000, 24'd200000, 24'd200000, 24'd190000, 24'd210000, 24'd200000});
        // exact half box and wrap across the boundary
        send_pair('{24'd163840, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
        send_pair('{24'd0, 24'd0, 24'd0, 24'd163840, 24'd0, 24'd0});
        send_pair('{24'd327000, 24'd100, 24'd0, 24'd500, 24'd327600, 24'd0});
        // just inside and at the cutoff
        send_pair('{24'd65535, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
        send_pair('{24'd65536, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
        // coordinates outside the box and field extremes
        send_pair('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0});
        send_pair('{24'h0, 24'h0, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
        send_pair('{24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555});
        // very close pairs clip the force
        send_pair('{24'd50, 24'd0, 24'd0, 24'd0, 24'd40, 24'd0});
        send_pair('{24'd0, 24'd300, 24'd0, 24'd0, 24'd0, 24'd310});
        end_burst();
        drain();
        // zero box length, zero well depth, zero sigma, then the largest sigma
        set_all(24'd0, 24'd1, 24'd0, 24'hFFFFFF, 24'd0, 24'd5898);
        send_pair('{24'd40000, 24'd5, 24'd0, 24'd0, 24'd3, 24'd9});
        end_burst();
        drain();
        write_reg(REG_EPS, 24'hFFFFFF);
        write_reg(REG_SIGMA_SQ, 24'd0);
        send_pair('{24'd40000, 24'd5, 24'd0, 24'd0, 24'd3, 24'd9});
        end_burst();
        drain();
        write_reg(REG_SIGMA_SQ, 24'hFFFFFF);
        send_pair('{24'd40000, 24'd5, 24'd0, 24'd0, 24'd3, 24'd9});
        send_pair('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0});
        send_pair('{24'd9, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
        end_burst();
        drain();
    endtask

    task automatic test_random_phase(logic [23:0] box, logic [23:0] cut, logic [23:0] e,
                                     logic [23:0] s, int count, int spread);
        pair_t p;
        set_all(box, box, box, cut, e, s);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) < 8)
                p = near_pair(box, spread);
            else
                p = pair_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
            send_pair(p, $urandom_range(0, 3) == 0);
        end
        end_burst();
        drain();
    endtask

    task automatic test_full_rate();
        sink_steady = 1'b1;
        for (int n = 0; n < 60; n++)
            send_pair(near_pair(24'd327680, 60000), 1'b1);
        end_burst();
        drain();
        sink_steady = 1'b0;
    endtask

    initial
    begin
        box_x = 24'd327680;
        box_y = 24'd327680;
        box_z = 24'd327680;
        cut_sq = 24'd65536;
        eps = 24'd32768;
        sig_sq = 24'd5898;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_rate();
        test_random_phase(24'd327680, 24'd65536, 24'd32768, 24'd5898, 200, 60000);
        test_random_phase(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 150, 3000000);
        test_random_phase(24'd1, 24'd0, 24'd65536, 24'd5898, 60, 4);
        test_random_phase(24'd65536, 24'd16384, 24'd200000, 24'd3000, 200, 20000);
        test_random_phase(24'd2000000, 24'd4000000, 24'd1000, 24'd100000, 200, 200000);

        repeat (100) @(posedge clk);
        $display("sent %0d pairs over several register settings; %0d forces checked,",
                 pairs_sent, forces_seen);
        $display("%0d within cutoff, %0d clipped", in_range_seen, sat_seen);
        if (errors == 0 && expected_forces.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
